[hw/rtl/door_access_alarm_controller_core_macros.svh]
// Assertion helpers for the door access alarm controller
`ifndef DOOR_ACCESS_ALARM_CONTROLLER_CORE_MACROS_SVH
`define DOOR_ACCESS_ALARM_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DAAC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DAAC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/daac_pkg.sv]
`default_nettype none

package daac_pkg;

    localparam int TIMER_BITS = 22;
    localparam int SEC_BITS   = 12;
    localparam int MS16_BITS  = 16;
    localparam int DEB_BITS   = 8;
    localparam int THR_BITS   = SEC_BITS + 10;
    localparam int CMP_BITS   = (TIMER_BITS > THR_BITS) ? TIMER_BITS : THR_BITS;
    localparam int MS_PER_S   = 1000;

    localparam int IN_BITS   = 24;
    localparam int OUT_BITS  = 8;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [SEC_BITS-1:0]  HELD_RST     = SEC_BITS'(30);
    localparam logic [SEC_BITS-1:0]  LATCH_RST    = SEC_BITS'(10);
    localparam logic [MS16_BITS-1:0] EXIT_RST     = MS16_BITS'(3000);
    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RST = DEB_BITS'(50);
    localparam logic [MS16_BITS-1:0] UNLOCK_RST   = MS16_BITS'(3000);

    typedef enum logic [1:0] {
        REG_HELD_TIMEOUT = 2'd0,
        REG_ALARM_LATCH  = 2'd1,
        REG_EXIT_UNLOCK  = 2'd2,
        REG_DEBOUNCE     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ALARM_CLEAR  = 2'd0,
        ALARM_FORCED = 2'd1,
        ALARM_HELD   = 2'd2
    } t_alarm;

    typedef struct packed {
        logic                 fire_override;
        logic [MS16_BITS-1:0] unlock_ms;
        logic                 unlock_request;
        logic                 button_level;
        logic                 door_sensor;
    } t_tick_in;

    typedef struct packed {
        logic   exit_event;
        logic   is_unlocked;
        logic   door_is_open;
        t_alarm alarm_code;
        logic   relay_on;
    } t_tick_out;

    function automatic logic [THR_BITS-1:0] sec_to_ms(input logic [SEC_BITS-1:0] s);
        sec_to_ms = THR_BITS'(s) * THR_BITS'(MS_PER_S);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/door_access_alarm_controller_core.sv]
// A request passes the input register, then the result register, before m_axis shows it.
// Throughput: one request per cycle while m_axis_tready stays high; the tick rules run
// in one registered pass.
// Results wait in an output register, so one more request is still taken while one waits.
// Reset (i_rst_n low, synchronous): registers return to their defaults, timers,
// alarm and unlock state clear, the button is taken as released.
`default_nettype none
`include "door_access_alarm_controller_core_macros.svh"

module door_access_alarm_controller_core
    import daac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // door_sensor, button_level, unlock_request, unlock_ms[15:0], fire_override, 4'b0
    input  wire logic [IN_BITS-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // relay_on, alarm_code[1:0], door_is_open, is_unlocked, exit_event, 2'b0
    output logic [OUT_BITS-1:0]       m_axis_tdata,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [MS16_BITS-1:0]  MS16_MAX  = '1;
    localparam logic [DEB_BITS-1:0]   DEB_MAX   = '1;

    logic [SEC_BITS-1:0]  r_held_s, r_latch_s;
    logic [THR_BITS-1:0]  r_held_thr, r_latch_thr;
    logic [MS16_BITS-1:0] r_exit_ms;
    logic [DEB_BITS-1:0]  r_debounce;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_s    <= HELD_RST;
            r_latch_s   <= LATCH_RST;
            r_held_thr  <= sec_to_ms(HELD_RST);
            r_latch_thr <= sec_to_ms(LATCH_RST);
            r_exit_ms   <= EXIT_RST;
            r_debounce  <= DEBOUNCE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HELD_TIMEOUT: begin
                    r_held_s   <= pwdata[SEC_BITS-1:0];
                    r_held_thr <= sec_to_ms(pwdata[SEC_BITS-1:0]);
                end
                REG_ALARM_LATCH: begin
                    r_latch_s   <= pwdata[SEC_BITS-1:0];
                    r_latch_thr <= sec_to_ms(pwdata[SEC_BITS-1:0]);
                end
                REG_EXIT_UNLOCK: r_exit_ms  <= pwdata[MS16_BITS-1:0];
                REG_DEBOUNCE:    r_debounce <= pwdata[DEB_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HELD_TIMEOUT: prdata = DATA_BITS'(r_held_s);
            REG_ALARM_LATCH:  prdata = DATA_BITS'(r_latch_s);
            REG_EXIT_UNLOCK:  prdata = DATA_BITS'(r_exit_ms);
            REG_DEBOUNCE:     prdata = DATA_BITS'(r_debounce);
            default:          prdata = '0;
        endcase
    end

    // input register
    logic     r_in_valid;
    t_tick_in r_in;
    logic     advance;

    assign advance       = r_in_valid & (~m_axis_tvalid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= t_tick_in'(s_axis_tdata[$bits(t_tick_in)-1:0]);
        end
    end

    // controller state
    logic                  r_unlocked, r_fire_active, r_button_last, r_door_open;
    logic [MS16_BITS-1:0]  r_unlock_len, r_unlock_elapsed;
    logic [DEB_BITS-1:0]   r_button_ms;
    logic [TIMER_BITS-1:0] r_door_ms, r_alarm_ms;
    t_alarm                r_alarm;

    logic                  n_unlocked, n_fire_active, n_door_open;
    logic [MS16_BITS-1:0]  n_unlock_len, n_unlock_elapsed;
    logic [DEB_BITS-1:0]   n_button_ms;
    logic [TIMER_BITS-1:0] n_door_ms, n_alarm_ms;
    t_alarm                n_alarm;
    logic                  n_exit;

    always_comb begin
        n_unlocked       = r_unlocked;
        n_fire_active    = r_fire_active;
        n_door_open      = r_door_open;
        n_unlock_len     = r_unlock_len;
        n_alarm          = r_alarm;
        n_exit           = 1'b0;
        n_unlock_elapsed = (r_unlock_elapsed == MS16_MAX) ? r_unlock_elapsed
                                                          : r_unlock_elapsed + 1'b1;
        n_button_ms      = (r_button_ms == DEB_MAX) ? r_button_ms : r_button_ms + 1'b1;
        n_door_ms        = (r_door_ms == TIMER_MAX) ? r_door_ms : r_door_ms + 1'b1;
        n_alarm_ms       = (r_alarm_ms == TIMER_MAX) ? r_alarm_ms : r_alarm_ms + 1'b1;

        if (r_in.fire_override && !n_fire_active) begin
            n_fire_active = 1'b1;
            n_unlocked    = 1'b1;
            n_alarm       = ALARM_CLEAR;
            n_alarm_ms    = '0;
        end else if (!r_in.fire_override && n_fire_active) begin
            n_fire_active = 1'b0;
            n_unlocked    = 1'b0;
        end

        if (r_in.unlock_request && !n_fire_active) begin
            n_unlock_len     = r_in.unlock_ms;
            n_unlock_elapsed = '0;
            n_unlocked       = 1'b1;
        end

        if (!n_fire_active && n_unlocked && n_unlock_elapsed >= n_unlock_len) begin
            n_unlocked = 1'b0;
        end

        if (r_in.door_sensor && !n_door_open) begin
            n_door_open = 1'b1;
            n_door_ms   = '0;
            if (!n_unlocked && !n_fire_active) begin
                n_alarm    = ALARM_FORCED;
                n_alarm_ms = '0;
            end
        end else if (!r_in.door_sensor && n_door_open) begin
            n_door_open = 1'b0;
            if (n_alarm == ALARM_HELD) begin
                n_alarm = ALARM_CLEAR;
            end
        end

        if (n_alarm == ALARM_FORCED) begin
            if (CMP_BITS'(n_alarm_ms) >= CMP_BITS'(r_latch_thr) && !r_in.door_sensor) begin
                n_alarm = ALARM_CLEAR;
            end
        end else if (n_alarm == ALARM_CLEAR && n_door_open && !n_fire_active) begin
            if (CMP_BITS'(n_door_ms) >= CMP_BITS'(r_held_thr)) begin
                n_alarm = ALARM_HELD;
            end
        end

        if (r_in.button_level != r_button_last) begin
            n_button_ms = '0;
        end
        if (n_button_ms > r_debounce && !r_in.button_level && !n_unlocked) begin
            n_exit = 1'b1;
            if (!n_fire_active) begin
                n_unlock_len     = r_exit_ms;
                n_unlock_elapsed = '0;
                n_unlocked       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlocked       <= 1'b0;
            r_fire_active    <= 1'b0;
            r_unlock_len     <= UNLOCK_RST;
            r_unlock_elapsed <= '0;
            r_button_last    <= 1'b1;
            r_button_ms      <= '0;
            r_door_open      <= 1'b0;
            r_door_ms        <= '0;
            r_alarm          <= ALARM_CLEAR;
            r_alarm_ms       <= '0;
        end else if (advance) begin
            r_unlocked       <= n_unlocked;
            r_fire_active    <= n_fire_active;
            r_unlock_len     <= n_unlock_len;
            r_unlock_elapsed <= n_unlock_elapsed;
            r_button_last    <= r_in.button_level;
            r_button_ms      <= n_button_ms;
            r_door_open      <= n_door_open;
            r_door_ms        <= n_door_ms;
            r_alarm          <= n_alarm;
            r_alarm_ms       <= n_alarm_ms;
        end
    end

    // result register
    t_tick_out r_out;
    t_tick_out n_out;

    always_comb begin
        n_out.relay_on     = n_unlocked | n_fire_active;
        n_out.alarm_code   = n_alarm;
        n_out.door_is_open = n_door_open;
        n_out.is_unlocked  = n_unlocked;
        n_out.exit_event   = n_exit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (advance) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tdata = OUT_BITS'(r_out);

    `DAAC_ASSERT_NOW(a_fire_holds_unlock, r_fire_active, r_unlocked, "fire active without unlock")
    `DAAC_ASSERT_NOW(a_fire_no_alarm, r_fire_active, r_alarm == ALARM_CLEAR, "alarm during fire")
    `DAAC_ASSERT_NOW(a_held_needs_open, !r_door_open, r_alarm != ALARM_HELD, "held alarm, door shut")
    `DAAC_ASSERT_NEXT(a_advance_fills_out, advance, m_axis_tvalid, "result lost after advance")

endmodule

`default_nettype wire
